@@ rtl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh
// concurrent assertion shorthands used by swq_checker
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define ASSERT_IMPLIES(name, clk, rst, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, disabled during reset
`define ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/swq_pkg.sv @@
// ----------------------------------------------------------------------------
// swq_pkg
// shared types and constants for the swept quad history search
// ----------------------------------------------------------------------------
package swq_pkg;

  localparam int THRESH_W     = 52;
  localparam logic [THRESH_W-1:0] THRESH_RESET = 52'd429497;

  localparam int AXES     = 3;
  localparam int PAIR_PTS = 6;
  // axis difference width, enough for the widest coordinate plus sign
  localparam int DIFF_W   = 34;
  // magnitudes at or above 2**MAG_BITS always count as far enough
  localparam int MAG_BITS = 26;
  localparam int SQ_W     = 2 * MAG_BITS;
  localparam int SUM_W    = SQ_W + 2;

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_SCAN   = 3'b010,
    ST_FINISH = 3'b100
  } state_t;

endpackage

@@ rtl/swept_quad_history_search.sv @@
// ----------------------------------------------------------------------------
// swept_quad_history_search
// ring history of tool endpoint pairs with a newest-to-oldest distance search
// ----------------------------------------------------------------------------
// usage
//   s_tdata carries one tool position: near x/y/z then far x/y/z, each
//   COORD_BITS signed, first field in the lowest bits. m_tuser is quad_valid,
//   m_tdata the found old pair in the same layout (zero when not found).
//   cfg_we/cfg_wdata load min_dist_sq, the squared threshold in Q32 units.
// timing
//   one request at a time; s_tready is low while a search runs.
//   the scan reads one history entry per cycle from a single-port memory
//   through a three-stage subtract/square/sum-compare pipe, covering the N
//   stored entries, at most HISTORY_DEPTH; with fewer than two entries no
//   scan runs. the scan stops at the first far-enough entry.
// reset and stall
//   rst clears the write pointer and entry count and reloads the default
//   threshold; the history memory is not cleared and is only read where written.
//   a stalled result waits in the output register; the next request is
//   accepted and searched meanwhile and waits for the slot before appending.
// ----------------------------------------------------------------------------
module swept_quad_history_search #(
  parameter int HISTORY_DEPTH = 512,
  parameter int COORD_BITS    = 24
) (
  input  logic                          clk,
  input  logic                          rst,
  // near_x, near_y, near_z, far_x, far_y, far_z
  input  logic [((6*COORD_BITS+7)/8)*8-1:0] s_tdata,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  // old_near_x, old_near_y, old_near_z, old_far_x, old_far_y, old_far_z
  output logic [((6*COORD_BITS+7)/8)*8-1:0] m_tdata,
  // quad_valid
  output logic                          m_tuser,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  input  logic                          cfg_we,
  input  logic [swq_pkg::THRESH_W-1:0]  cfg_wdata
);

  localparam int PAIR_W = swq_pkg::PAIR_PTS * COORD_BITS;
  localparam int DATA_W = ((PAIR_W + 7) / 8) * 8;
  localparam int AW     = $clog2(HISTORY_DEPTH);
  localparam int CW     = $clog2(HISTORY_DEPTH + 1);

  swq_pkg::state_t state, state_next;

  logic [swq_pkg::THRESH_W-1:0] min_dist_sq;
  logic [AW-1:0]     write_ptr;
  logic [CW-1:0]     entry_count;
  logic [AW-1:0]     rd_addr;
  logic [CW-1:0]     issue_cnt;
  logic [PAIR_W-1:0] in_pair;
  logic [PAIR_W-1:0] res_pair;
  logic              res_found;

  logic [PAIR_W-1:0] mem [HISTORY_DEPTH];

  logic              v1, v2, v3;
  logic [PAIR_W-1:0] rd_data, data2, data3;
  logic [swq_pkg::MAG_BITS-1:0] mag2 [swq_pkg::AXES];
  logic [swq_pkg::SQ_W-1:0]     sq3  [swq_pkg::AXES];
  logic              big2, big3;

  logic signed [swq_pkg::DIFF_W-1:0] diff_c [swq_pkg::AXES];
  logic [swq_pkg::DIFF_W-1:0]        mag_c  [swq_pkg::AXES];
  logic              big_c;
  logic [swq_pkg::SUM_W-1:0] sum_c;
  logic              hit;
  logic              issue_go;
  logic              drain_done;
  logic              accept;
  logic              out_free;
  logic              finish_go;

  assign s_tready   = (state == swq_pkg::ST_IDLE);
  assign accept     = s_tvalid && s_tready;
  assign out_free   = !m_tvalid || m_tready;
  assign finish_go  = (state == swq_pkg::ST_FINISH) && out_free;
  assign hit        = v3 && (big3 || (sum_c >= swq_pkg::SUM_W'(min_dist_sq)));
  assign issue_go   = (state == swq_pkg::ST_SCAN) && !hit && (issue_cnt != entry_count);
  assign drain_done = (issue_cnt == entry_count) && !v1 && !v2 && !v3;

  // subtract and magnitude per axis
  always_comb begin
    big_c = 1'b0;
    for (int k = 0; k < swq_pkg::AXES; k++) begin
      diff_c[k] = swq_pkg::DIFF_W'($signed(rd_data[k*COORD_BITS +: COORD_BITS]))
                - swq_pkg::DIFF_W'($signed(in_pair[k*COORD_BITS +: COORD_BITS]));
      mag_c[k]  = diff_c[k][swq_pkg::DIFF_W-1] ? swq_pkg::DIFF_W'(-diff_c[k])
                                               : swq_pkg::DIFF_W'(diff_c[k]);
      big_c     = big_c | (|mag_c[k][swq_pkg::DIFF_W-1:swq_pkg::MAG_BITS]);
    end
  end

  assign sum_c = swq_pkg::SUM_W'(sq3[0]) + swq_pkg::SUM_W'(sq3[1])
               + swq_pkg::SUM_W'(sq3[2]);

  always_comb begin
    state_next = state;
    unique case (state)
      swq_pkg::ST_IDLE: begin
        if (accept) begin
          state_next = (entry_count >= CW'(2)) ? swq_pkg::ST_SCAN : swq_pkg::ST_FINISH;
        end
      end
      swq_pkg::ST_SCAN: begin
        if (hit || drain_done) begin
          state_next = swq_pkg::ST_FINISH;
        end
      end
      swq_pkg::ST_FINISH: begin
        if (out_free) begin
          state_next = swq_pkg::ST_IDLE;
        end
      end
      default: state_next = swq_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= swq_pkg::ST_IDLE;
      min_dist_sq <= swq_pkg::THRESH_RESET;
      write_ptr   <= '0;
      entry_count <= '0;
      m_tvalid    <= 1'b0;
      v1          <= 1'b0;
      v2          <= 1'b0;
      v3          <= 1'b0;
      issue_cnt   <= '0;
      res_found   <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        min_dist_sq <= cfg_wdata;
      end
      if (hit || state != swq_pkg::ST_SCAN) begin
        v1 <= 1'b0;
        v2 <= 1'b0;
        v3 <= 1'b0;
      end else begin
        v1 <= issue_go;
        v2 <= v1;
        v3 <= v2;
      end
      if (accept) begin
        issue_cnt <= '0;
        res_found <= 1'b0;
      end else if (issue_go) begin
        issue_cnt <= issue_cnt + 1'b1;
      end
      if (hit) begin
        res_found <= 1'b1;
      end
      if (finish_go) begin
        m_tvalid  <= 1'b1;
        write_ptr <= (write_ptr == AW'(HISTORY_DEPTH - 1)) ? '0 : write_ptr + 1'b1;
        if (entry_count != CW'(HISTORY_DEPTH)) begin
          entry_count <= entry_count + 1'b1;
        end
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // payload and scan address
  always_ff @(posedge clk) begin
    if (accept) begin
      in_pair  <= s_tdata[PAIR_W-1:0];
      res_pair <= '0;
      rd_addr  <= (write_ptr == '0) ? AW'(HISTORY_DEPTH - 1) : write_ptr - 1'b1;
    end else if (issue_go) begin
      rd_addr  <= (rd_addr == '0) ? AW'(HISTORY_DEPTH - 1) : rd_addr - 1'b1;
    end
    if (hit) begin
      res_pair <= data3;
    end
    if (finish_go) begin
      m_tdata <= DATA_W'(res_pair);
      m_tuser <= res_found;
    end
  end

  // history memory
  always_ff @(posedge clk) begin
    if (finish_go) begin
      mem[write_ptr] <= in_pair;
    end
    if (issue_go) begin
      rd_data <= mem[rd_addr];
    end
  end

  // square and carry stages
  always_ff @(posedge clk) begin
    for (int k = 0; k < swq_pkg::AXES; k++) begin
      mag2[k] <= mag_c[k][swq_pkg::MAG_BITS-1:0];
      sq3[k]  <= mag2[k] * mag2[k];
    end
    big2  <= big_c;
    big3  <= big2;
    data2 <= rd_data;
    data3 <= data2;
  end

endmodule

@@ rtl/swq_checker.sv @@
// ----------------------------------------------------------------------------
// swq_checker
// port-level checks for the swept quad history search
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module swq_checker #(
  parameter int DATA_W = 144
) (
  input logic              clk,
  input logic              rst,
  input logic              s_tvalid,
  input logic              s_tready,
  input logic [DATA_W-1:0] m_tdata,
  input logic              m_tuser,
  input logic              m_tvalid,
  input logic              m_tready
);

  `ASSERT_NEXT(a_out_hold, clk, rst, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "stalled result changed")
  `ASSERT_NEXT(a_busy_after_req, clk, rst, s_tvalid && s_tready, !s_tready, "ready stayed high after a request")
  `ASSERT_IMPLIES(a_miss_zero, clk, rst, m_tvalid && !m_tuser, m_tdata == '0, "miss result carries data")
  `ASSERT_IMPLIES(a_result_idle, clk, rst, $rose(m_tvalid), s_tready, "new result while still searching")

endmodule

bind swept_quad_history_search swq_checker #(
  .DATA_W(DATA_W)
) u_swq_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready)
);
